// File: design/ipv4hc_pkg.sv
// Shared types and constants of the IPv4 header classifier.
package ipv4hc_pkg;

	// Action codes of an input item
	localparam logic [1:0] ACT_CLASSIFY = 2'd0;
	localparam logic [1:0] ACT_READ     = 2'd1;
	localparam logic [1:0] ACT_CLEAR    = 2'd2;

	// IP version nibbles
	localparam logic [3:0] VER_4 = 4'd4;
	localparam logic [3:0] VER_6 = 4'd6;

	localparam logic [5:0] MIN_HDR_BYTES = 6'd20;

	// Destination codes
	localparam logic [2:0] DEST_DROP    = 3'd0;
	localparam logic [2:0] DEST_DEFAULT = 3'd5;
	localparam logic [2:0] DEST_IPV6    = 3'd6;

	// Drop reasons
	localparam logic [3:0] RSN_NONE        = 4'd0;
	localparam logic [3:0] RSN_BAD_VERSION = 4'd1;
	localparam logic [3:0] RSN_NO_V6       = 4'd2;
	localparam logic [3:0] RSN_SHORT_CAP   = 4'd3;
	localparam logic [3:0] RSN_SHORT_HDR   = 4'd4;
	localparam logic [3:0] RSN_BAD_LENGTH  = 4'd5;
	localparam logic [3:0] RSN_ZERO_SRC    = 4'd6;
	localparam logic [3:0] RSN_ZERO_DST    = 4'd7;
	localparam logic [3:0] RSN_PROTO_ZERO  = 4'd8;
	localparam logic [3:0] RSN_FRAG        = 4'd9;

	// Configuration register indexes
	localparam logic [2:0] CFG_FILTER_FRAG = 3'd0;
	localparam logic [2:0] CFG_IPV6_EN     = 3'd1;
	localparam logic [2:0] CFG_ROUTE_BASE  = 3'd2;

	localparam int ROUTE_REGS = 4;
	localparam logic [8:0] ROUTE_UNUSED = 9'd256;
	localparam logic [8:0] STAT_TOTAL   = 9'd256;

	typedef logic [ROUTE_REGS-1:0][8:0] route_arr_t;

	// Verdict of the header checks
	typedef struct packed {
		logic [2:0] dest;
		logic [3:0] reason;
		logic       count;
	} verdict_t;

endpackage

// File: design/ipv4_header_classifier_with_stats.sv
// Top level of the IPv4 header classifier with per-protocol byte counters.
// An accepted item waits in stage 1 while its counter entry is read; its result
// is registered once the output register is free. A new item is taken only after
// the previous one has finished the counter read and the modify and write-back.
// Reset: asynchronous, active low; clears control state, configuration
// registers, the counter valid bits and the total; memory contents are not swept.
module ipv4_header_classifier_with_stats import ipv4hc_pkg::*; #(
	parameter int NUM_ROUTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [3:0]  version,
	input  logic [3:0]  header_words,
	input  logic [15:0] captured_length,
	input  logic [15:0] total_length,
	input  logic [31:0] source_address,
	input  logic [31:0] destination_address,
	input  logic [7:0]  protocol_number,
	input  logic        more_fragments,
	input  logic [12:0] fragment_offset_units,
	input  logic [8:0]  stat_index,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  destination,
	output logic [3:0]  drop_reason,
	output logic [63:0] stat_value
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic       filter_frag_q;
	logic       ipv6_en_q;
	route_arr_t route_q;
	logic [2:0] route_off;

	assign route_off = cfg_index - CFG_ROUTE_BASE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_frag_q <= 1'b0;
			ipv6_en_q     <= 1'b0;
			for (int i = 0; i < ROUTE_REGS; i++)
				route_q[i] <= ROUTE_UNUSED;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FILTER_FRAG)
				filter_frag_q <= cfg_data[0];
			else if (cfg_index == CFG_IPV6_EN)
				ipv6_en_q <= cfg_data[0];
			else if (cfg_index >= CFG_ROUTE_BASE && route_off < 3'(ROUTE_REGS))
				route_q[route_off[1:0]] <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// Header checks run on the accepted item straight from the ports;
	// the verdict is registered with the item so the write-back cycle only
	// has the 64-bit additions in it. The more-fragments flag plays no
	// part: there is no reassembly.
	// ------------------------------------------------------------------
	verdict_t verdict;

	ipv4hc_check #(
		.NUM_ROUTES(NUM_ROUTES)
	) u_check (
		.version              (version),
		.header_words         (header_words),
		.captured_length      (captured_length),
		.total_length         (total_length),
		.source_address       (source_address),
		.destination_address  (destination_address),
		.protocol_number      (protocol_number),
		.fragment_offset_units(fragment_offset_units),
		.filter_fragments     (filter_frag_q),
		.ipv6_enabled         (ipv6_en_q),
		.routes               (route_q),
		.verdict              (verdict)
	);

	// ------------------------------------------------------------------
	// Stage 1: item held while its counter entry is read
	// ------------------------------------------------------------------
	logic        busy_q;
	logic        in_fire;
	logic        done;
	logic [1:0]  action_s1;
	verdict_t    verdict_s1;
	logic [15:0] len_s1;
	logic [8:0]  idx_s1;
	logic [7:0]  addr_s1;
	logic [7:0]  rd_addr;

	// One item in flight; the finished result sits in the output register,
	// so the next item is taken even while the result waits downstream.
	assign in_ready = !busy_q;
	assign in_fire  = in_valid && in_ready;
	assign done     = busy_q && (!out_valid || out_ready);
	assign rd_addr  = (action == ACT_READ) ? stat_index[7:0] : protocol_number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (in_fire)
			busy_q <= 1'b1;
		else if (done)
			busy_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1  <= action;
			verdict_s1 <= verdict;
			len_s1     <= total_length;
			idx_s1     <= stat_index;
			addr_s1    <= rd_addr;
		end
	end

	// ------------------------------------------------------------------
	// Counter memory: 256 x 64, one write and one registered read port.
	// An entry whose valid bit is clear reads as zero, so a clear action
	// only drops the valid bits and clears the total. The next read is launched
	// no earlier than the edge after the write-back, so no forwarding is needed.
	// ------------------------------------------------------------------
	logic [63:0]  cnt_mem [256];
	logic [255:0] cnt_valid_q;
	logic [63:0]  rd_data_s1;
	logic [63:0]  total_q;
	logic [63:0]  entry_val;
	logic [63:0]  entry_sum;
	logic [63:0]  total_sum;
	logic [63:0]  len_ext;
	logic         mem_we;
	logic         clear_all;

	assign entry_val = cnt_valid_q[addr_s1] ? rd_data_s1 : 64'd0;
	assign len_ext   = {48'd0, len_s1};
	assign entry_sum = entry_val + len_ext;
	assign total_sum = total_q + len_ext;
	assign mem_we    = done && (action_s1 == ACT_CLASSIFY) && verdict_s1.count;
	assign clear_all = done && (action_s1 == ACT_CLEAR);

	always_ff @(posedge clk) begin
		if (mem_we)
			cnt_mem[addr_s1] <= entry_sum;
		if (in_fire)
			rd_data_s1 <= cnt_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_valid_q <= '0;
			total_q     <= 64'd0;
		end else if (clear_all) begin
			cnt_valid_q <= '0;
			total_q     <= 64'd0;
		end else if (mem_we) begin
			cnt_valid_q[addr_s1] <= 1'b1;
			total_q              <= total_sum;
		end
	end

	// ------------------------------------------------------------------
	// Result assembly and output register
	// ------------------------------------------------------------------
	logic [2:0]  dest_nx;
	logic [3:0]  reason_nx;
	logic [63:0] stat_nx;
	logic        out_valid_q;
	logic [2:0]  dest_q;
	logic [3:0]  reason_q;
	logic [63:0] stat_q;

	always_comb begin
		dest_nx   = DEST_DROP;
		reason_nx = RSN_NONE;
		stat_nx   = 64'd0;
		case (action_s1)
			ACT_CLASSIFY: begin
				dest_nx   = verdict_s1.dest;
				reason_nx = verdict_s1.reason;
			end
			ACT_READ: begin
				if (idx_s1 == STAT_TOTAL)
					stat_nx = total_q;
				else if (!idx_s1[8])
					stat_nx = entry_val;
			end
			default: begin
				// clear and unknown actions report all zero
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (done)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			dest_q   <= dest_nx;
			reason_q <= reason_nx;
			stat_q   <= stat_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign destination = dest_q;
	assign drop_reason = reason_q;
	assign stat_value  = stat_q;

endmodule

// File: design/ipv4hc_check.sv
// Header checks and protocol route lookup of the IPv4 header classifier.
module ipv4hc_check import ipv4hc_pkg::*; #(
	parameter int NUM_ROUTES = 4
) (
	input  logic [3:0]  version,
	input  logic [3:0]  header_words,
	input  logic [15:0] captured_length,
	input  logic [15:0] total_length,
	input  logic [31:0] source_address,
	input  logic [31:0] destination_address,
	input  logic [7:0]  protocol_number,
	input  logic [12:0] fragment_offset_units,
	input  logic        filter_fragments,
	input  logic        ipv6_enabled,
	input  route_arr_t  routes,
	output verdict_t    verdict
);

	localparam int ROUTE_LIMIT = (NUM_ROUTES < ROUTE_REGS) ? NUM_ROUTES : ROUTE_REGS;

	logic [5:0]  hdr_bytes;
	logic [15:0] hdr_bytes_ext;
	logic [2:0]  route_dest;

	assign hdr_bytes     = {header_words, 2'b00};
	assign hdr_bytes_ext = {10'd0, hdr_bytes};

	// first matching entry wins; unused entries hold a value above 255
	always_comb begin
		route_dest = DEST_DEFAULT;
		for (int i = ROUTE_LIMIT - 1; i >= 0; i--) begin
			if (routes[i] == {1'b0, protocol_number})
				route_dest = 3'(i + 1);
		end
	end

	always_comb begin
		verdict.dest   = DEST_DROP;
		verdict.reason = RSN_NONE;
		verdict.count  = 1'b0;
		if (version == VER_6) begin
			if (ipv6_enabled)
				verdict.dest = DEST_IPV6;
			else
				verdict.reason = RSN_NO_V6;
		end else if (version != VER_4) begin
			verdict.reason = RSN_BAD_VERSION;
		end else if (captured_length < hdr_bytes_ext) begin
			verdict.reason = RSN_SHORT_CAP;
		end else if (hdr_bytes < MIN_HDR_BYTES) begin
			verdict.reason = RSN_SHORT_HDR;
		end else if (total_length < hdr_bytes_ext) begin
			verdict.reason = RSN_BAD_LENGTH;
		end else if (source_address == 32'd0) begin
			verdict.reason = RSN_ZERO_SRC;
		end else if (destination_address == 32'd0) begin
			verdict.reason = RSN_ZERO_DST;
		end else if (protocol_number == 8'd0) begin
			verdict.reason = RSN_PROTO_ZERO;
		end else if (filter_fragments && (fragment_offset_units != 13'd0)) begin
			verdict.reason = RSN_FRAG;
		end else begin
			verdict.dest  = route_dest;
			verdict.count = 1'b1;
		end
	end

endmodule

// File: design/ipv4hc_checker.sv
// Port-level assertions for the IPv4 header classifier and their binding.
module ipv4hc_checker import ipv4hc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  destination,
	input logic [3:0]  drop_reason,
	input logic [63:0] stat_value
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(destination)
			&& $stable(drop_reason) && $stable(stat_value))
		else $error("stalled result changed");

	// one item in flight: no accept in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in flight");

	// a routed packet carries no drop reason
	a_routed_no_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && destination != DEST_DROP |-> drop_reason == RSN_NONE)
		else $error("routed item with a drop reason");

	// a counter value only comes with a read, which has no route and no reason
	a_stat_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stat_value != 64'd0 |-> destination == DEST_DROP
			&& drop_reason == RSN_NONE)
		else $error("counter value on a classify result");

	// codes stay within their defined ranges
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> destination <= DEST_IPV6 && drop_reason <= RSN_FRAG)
		else $error("result code out of range");

endmodule

bind ipv4_header_classifier_with_stats ipv4hc_checker u_ipv4hc_checker (.*);
